FILE: design/address_binding_table_top_assert.svh
// Assertion macros shared by the address binding table checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ADDRESS_BINDING_TABLE_TOP_ASSERT_SVH
`define ADDRESS_BINDING_TABLE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ABT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ABT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/abt_pkg.sv
// Types and constants of the address binding table.
// Used by abt_cell, address_binding_table_top and abt_checker.
package abt_pkg;

  localparam int unsigned ABT_TABLE_ENTRIES = 16;
  localparam int unsigned ABT_ADDRESS_BYTES = 18;
  localparam int unsigned ABT_MAC_W         = 144;
  localparam int unsigned ABT_KEY_W         = 22;
  localparam int unsigned ABT_LEN_W         = 5;
  localparam int unsigned ABT_SLOT_W        = 8;  // covers up to 256 slots
  localparam int unsigned ABT_COUNT_W       = 9;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_DELETE    = 2'd1,
    OP_FIND_ID   = 2'd2,
    OP_FIND_ADDR = 2'd3
  } abt_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } abt_status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [21:0] node_id;
    logic [63:0] mac_bytes_low;
    logic [63:0] mac_bytes_middle;
    logic [15:0] mac_bytes_top;
    logic [4:0]  mac_length;
  } abt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [21:0] found_id;
    logic [63:0] found_bytes_low;
    logic [63:0] found_bytes_middle;
    logic [15:0] found_bytes_top;
    logic [4:0]  found_length;
    logic [4:0]  entry_count;
  } abt_out_t;

  // query word moving along the cell row, gathering what each cell contributes
  typedef struct packed {
    logic                   vld;
    abt_op_e                op;
    logic [ABT_KEY_W-1:0]   key;
    logic [ABT_MAC_W-1:0]   mac;
    logic [ABT_LEN_W-1:0]   len;
    logic                   key_hit;
    logic [ABT_SLOT_W-1:0]  key_slot;
    logic                   free_hit;
    logic [ABT_SLOT_W-1:0]  free_slot;
    logic [ABT_COUNT_W-1:0] count;
    logic                   addr_hit;
    logic [ABT_KEY_W-1:0]   max_id;
    logic [ABT_MAC_W-1:0]   f_mac;
    logic [ABT_LEN_W-1:0]   f_len;
  } abt_token_t;

  // update broadcast to all cells once a scan is complete
  typedef struct packed {
    logic                  wr;
    logic                  del;
    logic [ABT_SLOT_W-1:0] slot;
    logic [ABT_KEY_W-1:0]  key;
    logic [ABT_MAC_W-1:0]  mac;
    logic [ABT_LEN_W-1:0]  len;
  } abt_commit_t;

endpackage

FILE: design/abt_cell.sv
// One table slot: holds a binding and adds its part to the passing query word.
// Depends on abt_pkg.
module abt_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abt_pkg::abt_token_t tok_i,
  input  abt_pkg::abt_commit_t cmt_i,
  output abt_pkg::abt_token_t tok_o
);

  localparam logic [abt_pkg::ABT_SLOT_W-1:0] MySlot = abt_pkg::ABT_SLOT_W'(INDEX);

  logic                           valid_q;
  logic [abt_pkg::ABT_KEY_W-1:0]  key_q;
  logic [abt_pkg::ABT_MAC_W-1:0]  mac_q;
  logic [abt_pkg::ABT_LEN_W-1:0]  len_q;
  abt_pkg::abt_token_t            tok_d, tok_q;
  logic                           match_key, match_addr, sel;

  assign sel        = (cmt_i.slot == MySlot);
  assign match_key  = valid_q && (key_q == tok_i.key);
  assign match_addr = valid_q && (tok_i.len != '0) && (len_q == tok_i.len) &&
                      (mac_q == tok_i.mac);

  always_comb begin
    tok_d = tok_i;
    if (match_key) begin
      tok_d.key_hit  = 1'b1;
      tok_d.key_slot = MySlot;
      tok_d.f_mac    = mac_q;
      tok_d.f_len    = len_q;
    end
    if (!valid_q && !tok_i.free_hit) begin
      tok_d.free_hit  = 1'b1;
      tok_d.free_slot = MySlot;
    end
    if (valid_q) begin
      tok_d.count = tok_i.count + abt_pkg::ABT_COUNT_W'(1);
    end
    if (match_addr && (!tok_i.addr_hit || (key_q > tok_i.max_id))) begin
      tok_d.addr_hit = 1'b1;
      tok_d.max_id   = key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (cmt_i.wr && sel) begin
        valid_q <= 1'b1;
      end else if (cmt_i.del && sel) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmt_i.wr && sel) begin
      key_q <= cmt_i.key;
      mac_q <= cmt_i.mac;
      len_q <= cmt_i.len;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: design/address_binding_table_top.sv
// Address binding table: a row of slot cells scanned by a query word.
// Depends on abt_pkg and abt_cell.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one operation word:
//   add, delete by id, find by id, or find by address. Output channel
//   out_valid_o / out_stall_i / out_data_o returns one result word per operation.
//   A word moves at a clock edge where valid is high and stall is low.
//
//   The query word passes one cell per cycle through the cell registers; at
//   the end of the row the result is registered in res_q, then in the output
//   register. One operation is in the table at a time; the next input is taken
//   only after the result is loaded into the output register. The cell row
//   length sets how long each operation takes.
//
//   Reset empties the table (all slots invalid) and clears both channels.
//   While the receiver stalls, the result word holds; a finished scan waits
//   in its own register, and no new input is taken until it moves on.
module address_binding_table_top #(
  parameter int unsigned TABLE_ENTRIES = abt_pkg::ABT_TABLE_ENTRIES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  abt_pkg::abt_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output abt_pkg::abt_out_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e               state_q, state_d;
  abt_pkg::abt_token_t  tok [TABLE_ENTRIES+1];
  abt_pkg::abt_token_t  inject;
  abt_pkg::abt_commit_t cmt;
  abt_pkg::abt_token_t  last;
  abt_pkg::abt_out_t    res_d, res_q, out_q;
  logic                 out_valid_q;
  logic                 accept, load_out;
  logic [abt_pkg::ABT_LEN_W-1:0] len_sat;
  logic [abt_pkg::ABT_MAC_W-1:0] mac_raw, mac_mask;
  logic [abt_pkg::ABT_COUNT_W-1:0] cnt;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // saturate length and clear bytes past it
  assign len_sat = (in_data_i.mac_length > abt_pkg::ABT_LEN_W'(abt_pkg::ABT_ADDRESS_BYTES))
                 ? abt_pkg::ABT_LEN_W'(abt_pkg::ABT_ADDRESS_BYTES) : in_data_i.mac_length;
  assign mac_raw = {in_data_i.mac_bytes_top, in_data_i.mac_bytes_middle,
                    in_data_i.mac_bytes_low};

  always_comb begin
    for (int b = 0; b < abt_pkg::ABT_MAC_W / 8; b++) begin
      mac_mask[b*8 +: 8] = (abt_pkg::ABT_LEN_W'(b) < len_sat) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    inject = '0;
    if (accept) begin
      inject.vld = 1'b1;
      inject.op  = abt_pkg::abt_op_e'(in_data_i.operation);
      inject.key = in_data_i.node_id;
      inject.mac = mac_raw & mac_mask;
      inject.len = len_sat;
    end
  end

  assign tok[0] = inject;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    abt_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[i]),
      .cmt_i (cmt),
      .tok_o (tok[i+1])
    );
  end

  assign last = tok[TABLE_ENTRIES];

  // table update once the word has seen every slot
  always_comb begin
    cmt      = '0;
    cmt.key  = last.key;
    cmt.mac  = last.mac;
    cmt.len  = last.len;
    if (last.op == abt_pkg::OP_DELETE) begin
      cmt.slot = last.key_slot;
    end else begin
      cmt.slot = last.free_slot;
    end
    cmt.wr  = last.vld && (last.op == abt_pkg::OP_ADD) && !last.key_hit && last.free_hit;
    cmt.del = last.vld && (last.op == abt_pkg::OP_DELETE) && last.key_hit;
  end

  always_comb begin
    res_d = '0;
    cnt   = last.count;
    case (last.op)
      abt_pkg::OP_ADD: begin
        if (last.key_hit) begin
          res_d.status = abt_pkg::ST_PRESENT;
        end else if (last.free_hit) begin
          res_d.status = abt_pkg::ST_OK;
          cnt = last.count + abt_pkg::ABT_COUNT_W'(1);
        end else begin
          res_d.status = abt_pkg::ST_FULL;
        end
      end
      abt_pkg::OP_DELETE: begin
        if (last.key_hit) begin
          res_d.status = abt_pkg::ST_OK;
          cnt = last.count - abt_pkg::ABT_COUNT_W'(1);
        end else begin
          res_d.status = abt_pkg::ST_NOT_FOUND;
        end
      end
      abt_pkg::OP_FIND_ID: begin
        if (last.key_hit) begin
          res_d.status             = abt_pkg::ST_OK;
          res_d.found_bytes_low    = last.f_mac[63:0];
          res_d.found_bytes_middle = last.f_mac[127:64];
          res_d.found_bytes_top    = last.f_mac[143:128];
          res_d.found_length       = last.f_len;
        end else begin
          res_d.status = abt_pkg::ST_NOT_FOUND;
        end
      end
      abt_pkg::OP_FIND_ADDR: begin
        if (last.addr_hit) begin
          res_d.status   = abt_pkg::ST_OK;
          res_d.found_id = last.max_id;
        end else begin
          res_d.status = abt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_d.status = abt_pkg::ST_NOT_FOUND;
      end
    endcase
    res_d.entry_count = cnt[4:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_SCAN;
      S_SCAN: if (last.vld) state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && last.vld) begin
      res_q <= res_d;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/abt_checker.sv
// Port-level checks for the address binding table, bound to the top level.
// Depends on abt_pkg and address_binding_table_top_assert.svh.
`include "address_binding_table_top_assert.svh"

module abt_checker #(
  parameter int unsigned TABLE_ENTRIES = abt_pkg::ABT_TABLE_ENTRIES
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input abt_pkg::abt_out_t out_data_o
);

  localparam logic [4:0] MaxCount = 5'(TABLE_ENTRIES);

  `ABT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "result word changed while stalled")

  `ABT_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o,
    "second word taken while an operation is in the table")

  `ABT_ASSERT_NOW(a_count_range, out_valid_o && (TABLE_ENTRIES < 32),
    out_data_o.entry_count <= MaxCount, "entry count above table size")

  `ABT_ASSERT_NOW(a_miss_zero,
    out_valid_o && (out_data_o.status != abt_pkg::ST_OK),
    (out_data_o.found_id == '0) && (out_data_o.found_length == '0) &&
    (out_data_o.found_bytes_low == '0) && (out_data_o.found_bytes_top == '0),
    "failed operation returned data")

endmodule

bind address_binding_table_top abt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_abt_checker (.*);
